[rtl/job_queue_page_drain_macros.svh]
// Assertion macros used by the port checker file.
`ifndef JOB_QUEUE_PAGE_DRAIN_MACROS_SVH
`define JOB_QUEUE_PAGE_DRAIN_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define JQPD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define JQPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/jqpd_pkg.sv]
// Package with shared types and constants of the job queue page drain block.
package jqpd_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W    = 16;
    localparam int PAGES_W = 16;
    localparam int CNT_W   = 5;
    localparam int TICK_W  = 8;
    localparam int PPT_W   = 8;
    localparam int BUDGET_W = TICK_W + PPT_W;
    localparam int CMD_FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_CHECK = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        func_t                func;
        logic [ID_W-1:0]      job_number;
        logic [PAGES_W-1:0]   job_pages;
        logic [BUDGET_W-1:0]  budget;
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic [PAGES_W-1:0] pages_left;
        logic [CNT_W-1:0]   jobs_waiting;
        logic [CNT_W-1:0]   jobs_finished;
        logic               add_rejected;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN_RD,
        ST_DRAIN,
        ST_SEARCH_RD,
        ST_SEARCH,
        ST_OUT
    } state_t;

    localparam int RESULT_W = $bits(result_t);
endpackage

[rtl/job_queue_page_drain.sv]
// Top level of the print job queue with page drain.
//   channel  | dir | fields
//   s_axis   | in  | tdata: func, job_number, job_pages, elapsed_ticks
//   m_axis   | out | tdata: found, pages_left, jobs_waiting, jobs_finished, add_rejected
//   cfg      | in  | pages_per_tick
// An add steps through IDLE, SEARCH and OUT; a tick passes DRAIN_RD and DRAIN once per
// popped or trimmed job; a check then passes SEARCH_RD and SEARCH once per searched entry.
// The back sequencer with its one RAM read port sets these steps.
// Reset is synchronous and active low; the job store needs no clearing.
// A two-entry command queue lets the front accept while the back works or stalls.
module job_queue_page_drain
    import jqpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], job_number[17:2], job_pages[33:18], elapsed_ticks[41:34]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0], pages_left[16:1], jobs_waiting[21:17], jobs_finished[26:22],
    // add_rejected[27]
    output logic [31:0] m_axis_tdata
);
    logic [PPT_W-1:0] ppt_reg;
    logic             cmd_valid, cmd_ready;
    cmd_t             cmd;
    result_t          res;

    // Pages per tick register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppt_reg <= PPT_W'(1);
        end else if (cfg_we) begin
            ppt_reg <= cfg_wdata;
        end
    end

    jqpd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .pages_per_tick(ppt_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_func(s_axis_tdata[1:0]), .in_job_number(s_axis_tdata[17:2]),
        .in_job_pages(s_axis_tdata[33:18]), .in_elapsed(s_axis_tdata[41:34]),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    jqpd_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {4'b0, res.add_rejected, res.jobs_finished, res.jobs_waiting,
                           res.pages_left, res.found};
endmodule

[rtl/jqpd_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module jqpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/jqpd_front.sv]
// Front part: accepts items, forms the page budget and queues commands.
module jqpd_front
    import jqpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [PPT_W-1:0]  pages_per_tick,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_func,
    input  logic [ID_W-1:0]   in_job_number,
    input  logic [PAGES_W-1:0] in_job_pages,
    input  logic [TICK_W-1:0] in_elapsed,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);
    localparam int PW = $clog2(CMD_FIFO_DEPTH);
    cmd_t          fifo_reg [CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   cnt_reg;
    cmd_t          new_cmd;
    logic          push, pop;

    // Classify the item and compute its budget.
    always_comb begin
        new_cmd.func       = func_t'(in_func);
        new_cmd.job_number = in_job_number;
        new_cmd.job_pages  = in_job_pages;
        new_cmd.budget     = in_elapsed * pages_per_tick;
    end

    assign in_ready  = (cnt_reg != (PW+1)'(CMD_FIFO_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Short command queue between the two parts.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= new_cmd;
        end
    end
endmodule

[rtl/jqpd_back.sv]
// Back part: runs add, drain and search over the job store.
module jqpd_back
    import jqpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  cmd_t     cmd,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int EW = $clog2(QUEUE_DEPTH + 1);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [EW-1:0]       count_reg, count_next;
    logic [EW-1:0]       done_reg, done_next;
    logic [EW-1:0]       idx_reg, idx_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    result_t             res_reg, res_next;

    logic                id_we, pg_we;
    logic [AW-1:0]       id_waddr, pg_waddr, raddr;
    logic [PAGES_W-1:0]  pg_wdata, pg_rdata;
    logic [ID_W-1:0]     id_rdata;

    jqpd_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_id_ram (
        .aclk(aclk), .we(id_we), .waddr(id_waddr), .wdata(cmd_reg.job_number),
        .raddr(raddr), .rdata(id_rdata)
    );
    jqpd_ram #(.WIDTH(PAGES_W), .DEPTH(QUEUE_DEPTH)) u_pg_ram (
        .aclk(aclk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
        .raddr(raddr), .rdata(pg_rdata)
    );

    // Slot a given distance behind a base slot, wrapping at the depth.
    function automatic logic [AW-1:0] slot_add(logic [AW-1:0] base, logic [EW-1:0] off);
        logic [EW:0] sum;
        sum = (EW+1)'(base) + (EW+1)'(off);
        if (sum >= (EW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (EW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Saturate a count to the five-bit result field.
    function automatic logic [CNT_W-1:0] sat5(logic [EW-1:0] v);
        if (32'(v) > 31) begin
            return '1;
        end
        return CNT_W'(v);
    endfunction

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    // Sequencer for one command at a time.
    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        idx_next    = idx_reg;
        budget_next = budget_reg;
        res_next    = res_reg;
        id_we       = 1'b0;
        pg_we       = 1'b0;
        id_waddr    = slot_add(head_reg, count_reg);
        pg_waddr    = id_waddr;
        pg_wdata    = cmd_reg.job_pages;
        raddr       = head_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_next    = cmd;
                    budget_next = cmd.budget;
                    done_next   = '0;
                    idx_next    = '0;
                    res_next    = '0;
                    case (cmd.func)
                        FUNC_ADD:   state_next = ST_SEARCH;
                        FUNC_TICK,
                        FUNC_CHECK: state_next = ST_DRAIN_RD;
                        default: begin
                            res_next.jobs_waiting = sat5(count_reg);
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_DRAIN_RD: begin
                // Read the front job's pages.
                if (count_reg == '0 || budget_reg == '0) begin
                    state_next = (cmd_reg.func == FUNC_CHECK) ? ST_SEARCH_RD : ST_OUT;
                    res_next.jobs_waiting  = sat5(count_reg);
                    res_next.jobs_finished = sat5(done_reg);
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (budget_reg >= BUDGET_W'(pg_rdata)) begin
                    budget_next = budget_reg - BUDGET_W'(pg_rdata);
                    head_next   = slot_add(head_reg, EW'(1));
                    count_next  = count_reg - 1'b1;
                    done_next   = done_reg + 1'b1;
                end else begin
                    pg_we       = 1'b1;
                    pg_waddr    = head_reg;
                    pg_wdata    = pg_rdata - PAGES_W'(budget_reg);
                    budget_next = '0;
                end
                state_next = ST_DRAIN_RD;
            end
            ST_SEARCH_RD: begin
                // Read the entry at the search position.
                raddr = slot_add(head_reg, idx_reg);
                if (idx_reg >= count_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (cmd_reg.func == FUNC_ADD) begin
                    // Append or reject the new job.
                    if (count_reg >= EW'(QUEUE_DEPTH)) begin
                        res_next.add_rejected = 1'b1;
                    end else begin
                        id_we      = 1'b1;
                        pg_we      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    res_next.jobs_waiting = sat5(count_next);
                    state_next = ST_OUT;
                end else if (id_rdata == cmd_reg.job_number) begin
                    res_next.found      = 1'b1;
                    res_next.pages_left = pg_rdata;
                    state_next = ST_OUT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SEARCH_RD;
                end
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
        cmd_reg    <= cmd_next;
        done_reg   <= done_next;
        idx_reg    <= idx_next;
        budget_reg <= budget_next;
        res_reg    <= res_next;
    end
endmodule

[rtl/jqpd_checker.sv]
// Port checker for the job queue page drain block, with its bind.
`include "job_queue_page_drain_macros.svh"
module jqpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // A stalled result holds its data.
    `JQPD_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // Padding bits stay zero.
    `JQPD_ASSERT_IMPL(a_pad, aclk, aresetn, m_axis_tvalid, m_axis_tdata[31:28] == 4'b0)
    // A found job and a rejected add never come together.
    `JQPD_ASSERT_IMPL(a_excl, aclk, aresetn, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[27]))
    // A result is never taken twice from one valid pulse.
    `JQPD_ASSERT_NEXT(a_drop, aclk, aresetn, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
endmodule

bind job_queue_page_drain jqpd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

[test/job_queue_page_drain_tb.sv]
// Self-checking testbench for the job queue page drain block.
`timescale 1ns / 1ps

module job_queue_page_drain_tb
    import jqpd_pkg::*;
();

    localparam int DEPTH = 16;

    // Expected result fields of one item.
    typedef struct {
        logic        found;
        logic [15:0] pages_left;
        logic [4:0]  jobs_waiting;
        logic [4:0]  jobs_finished;
        logic        add_rejected;
    } spool_result_t;

    // Predicts results of the job queue and checks the block against them.
    class spool_scoreboard;
        logic [15:0]   id_q[DEPTH];
        logic [15:0]   pg_q[DEPTH];
        int unsigned   head;
        int unsigned   count;
        int unsigned   ppt;
        spool_result_t pending[$];
        int            errors;

        function new();
            head = 0;
            count = 0;
            ppt = 1;
            errors = 0;
        endfunction

        function int unsigned drain_pages(int unsigned ticks);
            int unsigned budget;
            int unsigned done;
            budget = ticks * ppt;
            done = 0;
            while (count > 0 && budget > 0) begin
                if (budget >= pg_q[head]) begin
                    budget -= pg_q[head];
                    head = (head + 1) % DEPTH;
                    count--;
                    done++;
                end else begin
                    pg_q[head] = pg_q[head] - budget[15:0];
                    budget = 0;
                end
            end
            return done;
        endfunction

        // Notes an accepted item and queues its expected result.
        function void note_item(func_t fn, logic [15:0] jid, logic [15:0] jpg,
                                logic [7:0] ticks);
            spool_result_t r;
            int unsigned s;
            r = '{default: 0};
            case (fn)
                FUNC_ADD: begin
                    if (count >= DEPTH) begin
                        r.add_rejected = 1;
                    end else begin
                        s = (head + count) % DEPTH;
                        id_q[s] = jid;
                        pg_q[s] = jpg;
                        count++;
                    end
                end
                FUNC_TICK: begin
                    r.jobs_finished = 5'(drain_pages(32'(ticks)));
                end
                FUNC_CHECK: begin
                    r.jobs_finished = 5'(drain_pages(32'(ticks)));
                    for (int k = 0; k < count; k++) begin
                        s = (head + k) % DEPTH;
                        if (id_q[s] == jid) begin
                            r.found = 1;
                            r.pages_left = pg_q[s];
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.jobs_waiting = 5'(count);
            pending.push_back(r);
        endfunction

        // Compares one result item with the oldest expectation.
        function void check_result(logic [31:0] d);
            spool_result_t e;
            if (pending.size() == 0) begin
                $error("result item with no expectation: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[0] !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, d[0]);
                errors++;
            end
            if (d[16:1] !== e.pages_left) begin
                $error("pages_left: expected %0d, got %0d", e.pages_left, d[16:1]);
                errors++;
            end
            if (d[21:17] !== e.jobs_waiting) begin
                $error("jobs_waiting: expected %0d, got %0d", e.jobs_waiting, d[21:17]);
                errors++;
            end
            if (d[26:22] !== e.jobs_finished) begin
                $error("jobs_finished: expected %0d, got %0d", e.jobs_finished,
                       d[26:22]);
                errors++;
            end
            if (d[27] !== e.add_rejected) begin
                $error("add_rejected: expected %0d, got %0d", e.add_rejected, d[27]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [7:0]  cfg_wdata = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;

    spool_scoreboard sb;
    bit          sink_nostall = 0;
    bit          src_nogap = 0;

    job_queue_page_drain #(.QUEUE_DEPTH(DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    always #6 aclk = ~aclk;

    // Receiver: random stalls per item, checks at the rising edge.
    initial begin
        int gap;
        sb = new();
        forever begin
            gap = sink_nostall ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_axis_tready <= 1;
            do @(posedge aclk); while (!(m_axis_tvalid && aresetn));
            sb.check_result(m_axis_tdata);
            @(negedge aclk);
        end
    end

    // Sends one item; called at a falling edge and returns at a falling edge.
    // Valid stays high after the item so that a back-to-back item follows at once.
    task automatic send_item(func_t fn, logic [15:0] jid, logic [15:0] jpg,
                             logic [7:0] ticks);
        int gap;
        gap = src_nogap ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata <= {6'd0, ticks, jpg, jid, fn};
        s_axis_tvalid <= 1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_item(fn, jid, jpg, ticks);
        @(negedge aclk);
    endtask

    // Waits until every expected result has come, plus the block's latency.
    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_ppt(logic [7:0] v);
        wait_drained();
        cfg_wdata <= v;
        cfg_we <= 1;
        @(negedge aclk);
        cfg_we <= 0;
        sb.ppt = 32'(v);
    endtask

    // Mostly adds of small jobs and checks of small ids.
    task automatic random_item();
        int sel;
        logic [15:0] jid;
        logic [15:0] jpg;
        sel = $urandom_range(0, 99);
        jid = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        jpg = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        if (sel < 45)
            send_item(FUNC_ADD, jid, jpg, 8'($urandom));
        else if (sel < 65)
            send_item(FUNC_TICK, 16'($urandom), 16'($urandom), 8'($urandom_range(0, 6)));
        else if (sel < 95)
            send_item(FUNC_CHECK, jid, 16'($urandom), 8'($urandom_range(0, 4)));
        else
            send_item(func_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                      8'($urandom));
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: empty queue, zero budget, zero-page jobs, duplicates, full queue.
        send_item(FUNC_TICK, '0, '0, 8'd255);
        send_item(FUNC_CHECK, 16'hFFFF, '0, '0);
        send_item(FUNC_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(FUNC_ADD, 16'h0000, 16'd0, '0);
        send_item(FUNC_ADD, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(FUNC_ADD, 16'hFFFF, 16'd5, '0);
        send_item(FUNC_TICK, '0, '0, '0);
        send_item(FUNC_CHECK, 16'h0000, '0, '0);
        send_item(FUNC_CHECK, 16'hFFFF, '0, 8'd1);
        for (int i = 0; i < 15; i++)
            send_item(FUNC_ADD, 16'(i), 16'(i), '0);
        send_item(FUNC_NONE, '0, '0, '0);

        write_ppt(8'd255);
        send_item(FUNC_CHECK, 16'd7, '0, 8'd255);
        send_item(FUNC_TICK, '0, '0, 8'd255);

        // Random phases over several budget rates, extremes among them.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_ppt(8'd1);
                1: write_ppt(8'd255);
                2: write_ppt(8'd2);
                default: write_ppt(8'($urandom_range(1, 40)));
            endcase
            src_nogap = (ph == 3);
            sink_nostall = (ph == 4);
            for (int i = 0; i < 180; i++) begin
                random_item();
                if (i == 90) wait_drained();
            end
        end
        src_nogap = 0;
        sink_nostall = 0;
        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/jqpd_pkg.sv
rtl/jqpd_ram.sv
rtl/jqpd_front.sv
rtl/jqpd_back.sv
rtl/job_queue_page_drain.sv
rtl/jqpd_checker.sv
test/job_queue_page_drain_tb.sv
